[design/sci_pkg.sv]
// Shared types and widths for the segment / circle intersection block.
// Depends on nothing; used by the top level and its port checker.
package sci_pkg;

	// Coordinate format
	localparam int CW   = 32;          // coordinate width, two's complement
	localparam int FRAC = 16;          // fraction bits
	localparam int TW   = 32;          // tangent threshold register width
	localparam int RW   = CW - 1;      // radius width, unsigned

	// Derived datapath widths
	localparam int DW   = CW + 1;      // endpoint differences, signed
	localparam int HB   = CW + 1;      // half word for split multiplies
	localparam int PW   = 2 * DW;      // signed product of two differences
	localparam int AW   = 2 * CW + 2;  // |d|^2, unsigned
	localparam int HW   = 2 * CW + 3;  // h and c, signed
	localparam int HMW  = 2 * HB;      // magnitude of h, c and root numerators
	localparam int QMW  = 2 * HMW;     // magnitude of h*h and a*c
	localparam int QW   = QMW + 1;     // discriminant, signed
	localparam int SW   = QMW / 2;     // square root width, one bit per stage
	localparam int NW   = SW + 2;      // root numerator, signed
	localparam int PMW  = 3 * HB;      // |n * d|
	localparam int MW   = PMW + 2;     // dividend magnitude, one bit per stage
	localparam int EW   = AW + 1;      // divisor 2a
	localparam int CMPW = ((QW + 2 > TW + 3 * FRAC) ? QW + 2 : TW + 3 * FRAC) + 1;
	localparam int DEPTH = SW + MW + 15; // pipeline register stages

	localparam logic [TW-1:0] THR_RESET = TW'(66);

	typedef enum logic [1:0] {
		KIND_TANGENT = 2'd0,
		KIND_PLUS    = 2'd1,
		KIND_MINUS   = 2'd2
	} root_kind_t;

	typedef struct packed {
		logic signed [CW-1:0] seg_x1;
		logic signed [CW-1:0] seg_y1;
		logic signed [CW-1:0] seg_x2;
		logic signed [CW-1:0] seg_y2;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic [RW-1:0]        circle_radius;
	} sci_in_t;

	typedef struct packed {
		logic                 hit;
		root_kind_t           root_kind;
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic                 last;
	} sci_out_t;

endpackage

[design/segment_circle_intersection.sv]
// Segment / circle intersection top level: full datapath and result serializer.
// Depends on sci_pkg for types, widths and root kind codes.

// A new segment/circle item is taken in every cycle in which the result side
// is not holding back. Items flow through SW + MW + 15 register stages (182 at
// 32-bit coordinates) and then the result register before out_valid rises. The
// depth is set by the square root (one root bit per stage) and the four
// parallel dividers (one quotient bit per stage). An item with two
// intersection points occupies the result port for two transfers, which stalls
// the whole pipeline while the second is sent; items with one or no point
// sustain one per cycle while out_ready stays high.
// Each input gives either a single hit=0 item or one or two points, the final
// one marked last.
module segment_circle_intersection (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sci_pkg::sci_in_t       in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sci_pkg::sci_out_t      out_data,
	input  logic                   cfg_wr_en,
	input  logic [sci_pkg::TW-1:0] cfg_wr_data
);

	typedef struct packed {
		logic signed [sci_pkg::DW-1:0] p2x, p2y, dx, dy;
		logic [sci_pkg::RW-1:0]        r;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s2_t;

	typedef struct packed {
		logic signed [sci_pkg::PW-1:0] dxx, dyy, pdx, pdy, pxx, pyy;
		logic [2*sci_pkg::RW-1:0]      rr;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s3_t;

	typedef struct packed {
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::HW-1:0] h, c;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s4_t;

	typedef struct packed {
		logic [2*sci_pkg::HB-1:0]      hll, hlh, hhh, all, alh, ahl, ahh;
		logic                          c_neg;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::HW-1:0] hneg;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s5_t;

	typedef struct packed {
		logic [sci_pkg::QMW-1:0]       hh, ac;
		logic                          c_neg;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::HW-1:0] hneg;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s6_t;

	typedef struct packed {
		logic signed [sci_pkg::QW-1:0] q;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::HW-1:0] hneg;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s7_t;

	typedef struct packed {
		logic [sci_pkg::QMW-1:0]       rad;
		logic [sci_pkg::SW-1:0]        root;
		logic [sci_pkg::SW:0]          rem;
		logic                          ok, tan;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::HW-1:0] hneg;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} sq_t;

	typedef struct packed {
		logic                          av, bv, a_neg;
		sci_pkg::root_kind_t           kind_a;
		logic [sci_pkg::HMW-1:0]       a_mag, b_mag;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::DW-1:0] dx, dy;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s9_t;

	// lanes: 0 slot A x, 1 slot A y, 2 slot B x, 3 slot B y
	typedef struct packed {
		logic [3:0][2*sci_pkg::HB-1:0] plo, phi;
		logic [3:0]                    neg;
		logic                          av, bv;
		sci_pkg::root_kind_t           kind_a;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s10_t;

	typedef struct packed {
		logic [3:0][sci_pkg::PMW-1:0]  p;
		logic [3:0]                    neg;
		logic                          av, bv;
		sci_pkg::root_kind_t           kind_a;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s11_t;

	typedef struct packed {
		logic [3:0][sci_pkg::MW:0]     m;
		logic                          av, bv;
		sci_pkg::root_kind_t           kind_a;
		logic [sci_pkg::AW-1:0]        a;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s12_t;

	typedef struct packed {
		logic [sci_pkg::EW-1:0]        e;
		logic [3:0][sci_pkg::EW-1:0]   rem;
		logic [3:0][sci_pkg::MW-1:0]   mw;
		logic [3:0]                    mneg;
		logic                          av, bv;
		sci_pkg::root_kind_t           kind_a;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} dv_t;

	typedef struct packed {
		logic [3:0][sci_pkg::MW:0]     res;
		logic                          av, bv;
		sci_pkg::root_kind_t           kind_a;
		logic signed [sci_pkg::CW-1:0] x2, y2;
	} s14_t;

	typedef struct packed {
		logic [3:0][sci_pkg::CW-1:0]   pt;
		logic                          av, bv;
		sci_pkg::root_kind_t           kind_a;
	} s15_t;

	// one digit of the square root: two radicand bits in, one root bit out
	function automatic sq_t sq_step(input sq_t x);
		sq_t y;
		logic [sci_pkg::SW+2:0] t;
		logic [sci_pkg::SW+2:0] tr;
		logic [sci_pkg::SW+2:0] d;
		y = x;
		t = {x.rem, x.rad[sci_pkg::QMW-1 -: 2]};
		tr = {1'b0, x.root, 2'b01};
		d = t - tr;
		y.rad = {x.rad[sci_pkg::QMW-3:0], 2'b00};
		if (t >= tr) begin
			y.rem  = d[sci_pkg::SW:0];
			y.root = {x.root[sci_pkg::SW-2:0], 1'b1};
		end else begin
			y.rem  = t[sci_pkg::SW:0];
			y.root = {x.root[sci_pkg::SW-2:0], 1'b0};
		end
		return y;
	endfunction

	// one restoring division step in each of the four lanes
	function automatic dv_t dv_step(input dv_t x);
		dv_t y;
		logic [sci_pkg::EW:0] t;
		logic [sci_pkg::EW:0] d;
		y = x;
		for (int l = 0; l < 4; l++) begin
			t = {x.rem[l], x.mw[l][sci_pkg::MW-1]};
			d = t - {1'b0, x.e};
			if (t >= {1'b0, x.e}) begin
				y.rem[l] = d[sci_pkg::EW-1:0];
				y.mw[l]  = {x.mw[l][sci_pkg::MW-2:0], 1'b1};
			end else begin
				y.rem[l] = t[sci_pkg::EW-1:0];
				y.mw[l]  = {x.mw[l][sci_pkg::MW-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	// clamp to the signed coordinate range
	function automatic logic [sci_pkg::CW-1:0] sat_coord(input logic [sci_pkg::MW+1:0] s);
		logic fits;
		fits = (&s[sci_pkg::MW+1:sci_pkg::CW-1]) | ~(|s[sci_pkg::MW+1:sci_pkg::CW-1]);
		if (fits)
			return s[sci_pkg::CW-1:0];
		else if (s[sci_pkg::MW+1])
			return {1'b1, {(sci_pkg::CW-1){1'b0}}};
		else
			return {1'b0, {(sci_pkg::CW-1){1'b1}}};
	endfunction

	logic [sci_pkg::TW-1:0]    thr_q;
	logic [sci_pkg::DEPTH-1:0] vld_q;
	logic                      adv;

	sci_pkg::sci_in_t in_s1;
	s2_t  p_s2;
	s3_t  p_s3;
	s4_t  p_s4;
	s5_t  p_s5;
	s6_t  p_s6;
	s7_t  p_s7;
	sq_t  sq_s8 [0:sci_pkg::SW];
	s9_t  p_s9;
	s10_t p_s10;
	s11_t p_s11;
	s12_t p_s12;
	dv_t  dv_s13 [0:sci_pkg::MW];
	s14_t p_s14;
	s15_t p_s15;

	logic              ser_v_q, sec_q;
	sci_pkg::sci_out_t res0_q, res1_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= sci_pkg::THR_RESET;
		else if (cfg_wr_en)
			thr_q <= cfg_wr_data;
	end

	// whole pipeline moves together; it halts while the serializer is held or sends a second point
	assign adv      = !ser_v_q || (out_ready && !sec_q);
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[sci_pkg::DEPTH-2:0], in_valid};
	end

	// front end: shift to circle origin, products, a/h/c
	logic [sci_pkg::HMW-1:0] habs_c, cabs_c;
	assign habs_c = sci_pkg::HMW'(p_s4.h[sci_pkg::HW-1] ? -p_s4.h : p_s4.h);
	assign cabs_c = sci_pkg::HMW'(p_s4.c[sci_pkg::HW-1] ? -p_s4.c : p_s4.c);

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= in_data;

			p_s2.p2x <= sci_pkg::DW'(in_s1.seg_x2) - sci_pkg::DW'(in_s1.center_x);
			p_s2.p2y <= sci_pkg::DW'(in_s1.seg_y2) - sci_pkg::DW'(in_s1.center_y);
			p_s2.dx  <= sci_pkg::DW'(in_s1.seg_x1) - sci_pkg::DW'(in_s1.seg_x2);
			p_s2.dy  <= sci_pkg::DW'(in_s1.seg_y1) - sci_pkg::DW'(in_s1.seg_y2);
			p_s2.r   <= in_s1.circle_radius;
			p_s2.x2  <= in_s1.seg_x2;
			p_s2.y2  <= in_s1.seg_y2;

			p_s3.dxx <= p_s2.dx * p_s2.dx;
			p_s3.dyy <= p_s2.dy * p_s2.dy;
			p_s3.pdx <= p_s2.p2x * p_s2.dx;
			p_s3.pdy <= p_s2.p2y * p_s2.dy;
			p_s3.pxx <= p_s2.p2x * p_s2.p2x;
			p_s3.pyy <= p_s2.p2y * p_s2.p2y;
			p_s3.rr  <= p_s2.r * p_s2.r;
			p_s3.dx  <= p_s2.dx;
			p_s3.dy  <= p_s2.dy;
			p_s3.x2  <= p_s2.x2;
			p_s3.y2  <= p_s2.y2;

			p_s4.a  <= sci_pkg::AW'(sci_pkg::HW'(p_s3.dxx) + sci_pkg::HW'(p_s3.dyy));
			p_s4.h  <= sci_pkg::HW'(p_s3.pdx) + sci_pkg::HW'(p_s3.pdy);
			p_s4.c  <= sci_pkg::HW'(p_s3.pxx) + sci_pkg::HW'(p_s3.pyy)
				- sci_pkg::HW'(p_s3.rr);
			p_s4.dx <= p_s3.dx;
			p_s4.dy <= p_s3.dy;
			p_s4.x2 <= p_s3.x2;
			p_s4.y2 <= p_s3.y2;

			// split h*h and a*|c| into half-word partial products
			p_s5.hll   <= habs_c[sci_pkg::HB-1:0] * habs_c[sci_pkg::HB-1:0];
			p_s5.hlh   <= habs_c[sci_pkg::HB-1:0] * habs_c[sci_pkg::HMW-1:sci_pkg::HB];
			p_s5.hhh   <= habs_c[sci_pkg::HMW-1:sci_pkg::HB] * habs_c[sci_pkg::HMW-1:sci_pkg::HB];
			p_s5.all   <= p_s4.a[sci_pkg::HB-1:0] * cabs_c[sci_pkg::HB-1:0];
			p_s5.alh   <= p_s4.a[sci_pkg::HB-1:0] * cabs_c[sci_pkg::HMW-1:sci_pkg::HB];
			p_s5.ahl   <= p_s4.a[sci_pkg::AW-1:sci_pkg::HB] * cabs_c[sci_pkg::HB-1:0];
			p_s5.ahh   <= p_s4.a[sci_pkg::AW-1:sci_pkg::HB] * cabs_c[sci_pkg::HMW-1:sci_pkg::HB];
			p_s5.c_neg <= p_s4.c[sci_pkg::HW-1];
			p_s5.a     <= p_s4.a;
			p_s5.hneg  <= -p_s4.h;
			p_s5.dx    <= p_s4.dx;
			p_s5.dy    <= p_s4.dy;
			p_s5.x2    <= p_s4.x2;
			p_s5.y2    <= p_s4.y2;

			p_s6.hh    <= sci_pkg::QMW'(p_s5.hll)
				+ (sci_pkg::QMW'(p_s5.hlh) << (sci_pkg::HB + 1))
				+ (sci_pkg::QMW'(p_s5.hhh) << (2 * sci_pkg::HB));
			p_s6.ac    <= sci_pkg::QMW'(p_s5.all)
				+ (sci_pkg::QMW'(p_s5.alh) << sci_pkg::HB)
				+ (sci_pkg::QMW'(p_s5.ahl) << sci_pkg::HB)
				+ (sci_pkg::QMW'(p_s5.ahh) << (2 * sci_pkg::HB));
			p_s6.c_neg <= p_s5.c_neg;
			p_s6.a     <= p_s5.a;
			p_s6.hneg  <= p_s5.hneg;
			p_s6.dx    <= p_s5.dx;
			p_s6.dy    <= p_s5.dy;
			p_s6.x2    <= p_s5.x2;
			p_s6.y2    <= p_s5.y2;

			// discriminant q = h*h - a*c
			p_s7.q    <= p_s6.c_neg ? sci_pkg::QW'(p_s6.hh) + sci_pkg::QW'(p_s6.ac)
				: sci_pkg::QW'(p_s6.hh) - sci_pkg::QW'(p_s6.ac);
			p_s7.a    <= p_s6.a;
			p_s7.hneg <= p_s6.hneg;
			p_s7.dx   <= p_s6.dx;
			p_s7.dy   <= p_s6.dy;
			p_s7.x2   <= p_s6.x2;
			p_s7.y2   <= p_s6.y2;
		end
	end

	// square root entry: classify the discriminant
	sq_t sq_in;
	always_comb begin
		sq_in      = '0;
		sq_in.rad  = p_s7.q[sci_pkg::QMW-1:0];
		sq_in.ok   = (p_s7.a != '0) && !p_s7.q[sci_pkg::QW-1];
		sq_in.tan  = sci_pkg::CMPW'({p_s7.q, 2'b00})
			< (sci_pkg::CMPW'(thr_q) << (3 * sci_pkg::FRAC));
		sq_in.a    = p_s7.a;
		sq_in.hneg = p_s7.hneg;
		sq_in.dx   = p_s7.dx;
		sq_in.dy   = p_s7.dy;
		sq_in.x2   = p_s7.x2;
		sq_in.y2   = p_s7.y2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s8[0] <= sq_in;
			for (int k = 0; k < sci_pkg::SW; k++)
				sq_s8[k+1] <= sq_step(sq_s8[k]);
		end
	end

	// root numerators and range check
	sq_t                           sq_o;
	logic signed [sci_pkg::NW-1:0] np_c, nm_c;
	logic                          np_ok, nm_ok;
	s9_t                           s9_d;
	assign sq_o = sq_s8[sci_pkg::SW];
	always_comb begin
		np_c   = sci_pkg::NW'(sq_o.hneg) + sci_pkg::NW'(sq_o.root);
		nm_c   = sci_pkg::NW'(sq_o.hneg) - sci_pkg::NW'(sq_o.root);
		np_ok  = !np_c[sci_pkg::NW-1] && (np_c <= sci_pkg::NW'(sq_o.a));
		nm_ok  = !nm_c[sci_pkg::NW-1] && (nm_c <= sci_pkg::NW'(sq_o.a));
		s9_d.av = sq_o.ok && (sq_o.tan || np_ok);
		s9_d.bv = sq_o.ok && !sq_o.tan && nm_ok;
		if (sq_o.tan) begin
			s9_d.kind_a = sci_pkg::KIND_TANGENT;
			s9_d.a_neg  = sq_o.hneg[sci_pkg::HW-1];
			s9_d.a_mag  = sci_pkg::HMW'(sq_o.hneg[sci_pkg::HW-1] ? -sq_o.hneg : sq_o.hneg);
		end else begin
			s9_d.kind_a = sci_pkg::KIND_PLUS;
			s9_d.a_neg  = 1'b0;
			s9_d.a_mag  = np_c[sci_pkg::HMW-1:0];
		end
		s9_d.b_mag = nm_c[sci_pkg::HMW-1:0];
		s9_d.a     = sq_o.a;
		s9_d.dx    = sq_o.dx;
		s9_d.dy    = sq_o.dy;
		s9_d.x2    = sq_o.x2;
		s9_d.y2    = sq_o.y2;
	end

	// numerator times direction: two half-word products per lane
	logic [sci_pkg::HB-1:0]  dxm_c, dym_c;
	logic [sci_pkg::HMW-1:0] nmag_c [4];
	logic [sci_pkg::HB-1:0]  dmag_c [4];
	logic [3:0]              lneg_c;
	assign dxm_c = sci_pkg::HB'(p_s9.dx[sci_pkg::DW-1] ? -p_s9.dx : p_s9.dx);
	assign dym_c = sci_pkg::HB'(p_s9.dy[sci_pkg::DW-1] ? -p_s9.dy : p_s9.dy);
	always_comb begin
		nmag_c[0] = p_s9.a_mag;
		nmag_c[1] = p_s9.a_mag;
		nmag_c[2] = p_s9.b_mag;
		nmag_c[3] = p_s9.b_mag;
		dmag_c[0] = dxm_c;
		dmag_c[1] = dym_c;
		dmag_c[2] = dxm_c;
		dmag_c[3] = dym_c;
		lneg_c[0] = p_s9.a_neg ^ p_s9.dx[sci_pkg::DW-1];
		lneg_c[1] = p_s9.a_neg ^ p_s9.dy[sci_pkg::DW-1];
		lneg_c[2] = p_s9.dx[sci_pkg::DW-1];
		lneg_c[3] = p_s9.dy[sci_pkg::DW-1];
	end

	// rounding dividend m = 2*n*d + a, then |m| into the dividers
	dv_t dv_in;
	always_comb begin
		dv_in        = '0;
		dv_in.e      = {p_s12.a, 1'b0};
		dv_in.av     = p_s12.av;
		dv_in.bv     = p_s12.bv;
		dv_in.kind_a = p_s12.kind_a;
		dv_in.x2     = p_s12.x2;
		dv_in.y2     = p_s12.y2;
		for (int l = 0; l < 4; l++) begin
			dv_in.mneg[l] = p_s12.m[l][sci_pkg::MW];
			dv_in.mw[l]   = sci_pkg::MW'(p_s12.m[l][sci_pkg::MW] ? -p_s12.m[l] : p_s12.m[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9 <= s9_d;

			for (int l = 0; l < 4; l++) begin
				p_s10.plo[l] <= nmag_c[l][sci_pkg::HB-1:0] * dmag_c[l];
				p_s10.phi[l] <= nmag_c[l][sci_pkg::HMW-1:sci_pkg::HB] * dmag_c[l];
			end
			p_s10.neg    <= lneg_c;
			p_s10.av     <= p_s9.av;
			p_s10.bv     <= p_s9.bv;
			p_s10.kind_a <= p_s9.kind_a;
			p_s10.a      <= p_s9.a;
			p_s10.x2     <= p_s9.x2;
			p_s10.y2     <= p_s9.y2;

			for (int l = 0; l < 4; l++)
				p_s11.p[l] <= sci_pkg::PMW'(p_s10.plo[l])
					+ (sci_pkg::PMW'(p_s10.phi[l]) << sci_pkg::HB);
			p_s11.neg    <= p_s10.neg;
			p_s11.av     <= p_s10.av;
			p_s11.bv     <= p_s10.bv;
			p_s11.kind_a <= p_s10.kind_a;
			p_s11.a      <= p_s10.a;
			p_s11.x2     <= p_s10.x2;
			p_s11.y2     <= p_s10.y2;

			for (int l = 0; l < 4; l++)
				p_s12.m[l] <= p_s11.neg[l]
					? (sci_pkg::MW+1)'(p_s11.a) - (sci_pkg::MW+1)'({p_s11.p[l], 1'b0})
					: (sci_pkg::MW+1)'(p_s11.a) + (sci_pkg::MW+1)'({p_s11.p[l], 1'b0});
			p_s12.av     <= p_s11.av;
			p_s12.bv     <= p_s11.bv;
			p_s12.kind_a <= p_s11.kind_a;
			p_s12.a      <= p_s11.a;
			p_s12.x2     <= p_s11.x2;
			p_s12.y2     <= p_s11.y2;

			dv_s13[0] <= dv_in;
			for (int k = 0; k < sci_pkg::MW; k++)
				dv_s13[k+1] <= dv_step(dv_s13[k]);
		end
	end

	// floor of a signed quotient, then offset by the second endpoint and clamp
	dv_t dv_o;
	assign dv_o = dv_s13[sci_pkg::MW];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 4; l++)
				p_s14.res[l] <= dv_o.mneg[l]
					? -((sci_pkg::MW+1)'(dv_o.mw[l]) + (sci_pkg::MW+1)'(|dv_o.rem[l]))
					: (sci_pkg::MW+1)'(dv_o.mw[l]);
			p_s14.av     <= dv_o.av;
			p_s14.bv     <= dv_o.bv;
			p_s14.kind_a <= dv_o.kind_a;
			p_s14.x2     <= dv_o.x2;
			p_s14.y2     <= dv_o.y2;

			p_s15.pt[0] <= sat_coord({p_s14.res[0][sci_pkg::MW], p_s14.res[0]}
				+ (sci_pkg::MW+2)'(p_s14.x2));
			p_s15.pt[1] <= sat_coord({p_s14.res[1][sci_pkg::MW], p_s14.res[1]}
				+ (sci_pkg::MW+2)'(p_s14.y2));
			p_s15.pt[2] <= sat_coord({p_s14.res[2][sci_pkg::MW], p_s14.res[2]}
				+ (sci_pkg::MW+2)'(p_s14.x2));
			p_s15.pt[3] <= sat_coord({p_s14.res[3][sci_pkg::MW], p_s14.res[3]}
				+ (sci_pkg::MW+2)'(p_s14.y2));
			p_s15.av     <= p_s14.av;
			p_s15.bv     <= p_s14.bv;
			p_s15.kind_a <= p_s14.kind_a;
		end
	end

	// result serializer: up to two transfers per item
	sci_pkg::sci_out_t first_c, second_c;
	always_comb begin
		second_c.hit       = 1'b1;
		second_c.root_kind = sci_pkg::KIND_MINUS;
		second_c.point_x   = p_s15.pt[2];
		second_c.point_y   = p_s15.pt[3];
		second_c.last      = 1'b1;
		if (p_s15.av) begin
			first_c.hit       = 1'b1;
			first_c.root_kind = p_s15.kind_a;
			first_c.point_x   = p_s15.pt[0];
			first_c.point_y   = p_s15.pt[1];
			first_c.last      = !p_s15.bv;
		end else if (p_s15.bv) begin
			first_c = second_c;
		end else begin
			first_c.hit       = 1'b0;
			first_c.root_kind = sci_pkg::KIND_TANGENT;
			first_c.point_x   = '0;
			first_c.point_y   = '0;
			first_c.last      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			sec_q   <= 1'b0;
		end else if (adv) begin
			ser_v_q <= vld_q[sci_pkg::DEPTH-1];
			sec_q   <= vld_q[sci_pkg::DEPTH-1] && p_s15.av && p_s15.bv;
		end else if (out_ready) begin
			sec_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res0_q <= first_c;
			res1_q <= second_c;
		end else if (out_ready) begin
			res0_q <= res1_q;
		end
	end

	assign out_valid = ser_v_q;
	always_comb begin
		out_data      = res0_q;
		out_data.last = !sec_q;
	end

endmodule

[design/sci_checker.sv]
// Port-level checker for the segment / circle intersection block, bound to it.
// Depends on sci_pkg for the port types and root kind codes.
module sci_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input sci_pkg::sci_in_t       in_data,
	input logic                   out_valid,
	input logic                   out_ready,
	input sci_pkg::sci_out_t      out_data,
	input logic                   cfg_wr_en,
	input logic [sci_pkg::TW-1:0] cfg_wr_data
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an item without a point closes its input and carries zeros
	a_miss_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.last && out_data.point_x == '0
			&& out_data.point_y == '0 && out_data.root_kind == sci_pkg::KIND_TANGENT)
		else $error("no-point item malformed");

	// only a plus root can be followed by another point
	a_first_plus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.hit
			&& out_data.root_kind == sci_pkg::KIND_PLUS)
		else $error("non-final item is not a plus root");

	// after a non-final transfer the minus root follows
	a_then_minus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid && out_data.hit
			&& out_data.last && out_data.root_kind == sci_pkg::KIND_MINUS)
		else $error("second root missing");

endmodule

bind segment_circle_intersection sci_checker u_sci_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// Testbench for segment_circle_intersection: a queued driver, a monitor and an
// exact integer predictor of the intersection points. Depends on sci_pkg and the RTL.
module testbench;

	typedef logic signed [255:0] wide_t;

	localparam int IDLE_LIMIT = 6000;
	localparam int DRAIN_WAIT = 220;
	localparam int LONG_HOLD  = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sci_pkg::sci_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sci_pkg::sci_out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [sci_pkg::TW-1:0] cfg_wr_data = '0;

	sci_pkg::sci_in_t pending_segs[$];
	sci_pkg::sci_out_t expected_points[$];
	logic [sci_pkg::TW-1:0] cur_thr = sci_pkg::THR_RESET;
	logic send_hold = 1'b0;
	int hold_seq = 0;
	int errors = 0;

	segment_circle_intersection uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #6 clk = ~clk;

	// saturate to the signed coordinate range
	function automatic logic signed [sci_pkg::CW-1:0] sat_coord(input wide_t v);
		if (v > wide_t'(64'sd2147483647)) return 32'sh7fffffff;
		if (v < -wide_t'(64'sd2147483648)) return 32'sh80000000;
		return v[sci_pkg::CW-1:0];
	endfunction

	// floor((2n + d) / 2d): nearest, ties toward plus infinity
	function automatic wide_t div_nearest(input wide_t n, input wide_t d);
		wide_t m, e, q;
		m = 2 * n + d;
		e = 2 * d;
		q = m / e;
		if (m < 0 && q * e != m) q = q - 1;
		return q;
	endfunction

	function automatic logic [255:0] isqrt(input logic [255:0] q);
		logic [255:0] r, c;
		r = '0;
		for (int i = 127; i >= 0; i--) begin
			c = r | (256'd1 << i);
			if (c * c <= q) r = c;
		end
		return r;
	endfunction

	// expected points of one segment/circle transfer
	function automatic void predict_points(input sci_pkg::sci_in_t s);
		wide_t x1, y1, x2, y2, cx, cy, r, p2x, p2y, dx, dy, a, h, c, q, sq, nh, nr;
		sci_pkg::sci_out_t o;
		int k;
		x1 = wide_t'($signed(s.seg_x1));
		y1 = wide_t'($signed(s.seg_y1));
		x2 = wide_t'($signed(s.seg_x2));
		y2 = wide_t'($signed(s.seg_y2));
		cx = wide_t'($signed(s.center_x));
		cy = wide_t'($signed(s.center_y));
		r = wide_t'({1'b0, s.circle_radius});
		p2x = x2 - cx;
		p2y = y2 - cy;
		dx = x1 - x2;
		dy = y1 - y2;
		a = dx * dx + dy * dy;
		h = p2x * dx + p2y * dy;
		c = p2x * p2x + p2y * p2y - r * r;
		q = h * h - a * c;
		nh = -h;
		k = 0;
		o = '0;
		if (a != 0 && q >= 0) begin
			if (4 * q < (wide_t'({1'b0, cur_thr}) <<< (3 * sci_pkg::FRAC))) begin
				o.hit = 1'b1;
				o.root_kind = sci_pkg::KIND_TANGENT;
				o.point_x = sat_coord(x2 + div_nearest(nh * dx, a));
				o.point_y = sat_coord(y2 + div_nearest(nh * dy, a));
				expected_points.push_back(o);
				k++;
			end else begin
				sq = wide_t'(isqrt(q));
				for (int i = 0; i < 2; i++) begin
					nr = (i == 0) ? nh + sq : nh - sq;
					if (nr >= 0 && nr <= a) begin
						o.hit = 1'b1;
						o.root_kind = (i == 0) ? sci_pkg::KIND_PLUS : sci_pkg::KIND_MINUS;
						o.point_x = sat_coord(x2 + div_nearest(nr * dx, a));
						o.point_y = sat_coord(y2 + div_nearest(nr * dy, a));
						expected_points.push_back(o);
						k++;
					end
				end
			end
		end
		if (k == 0) begin
			o = '0;
			expected_points.push_back(o);
		end
		o = expected_points[$];
		o.last = 1'b1;
		expected_points[$] = o;
	endfunction

	function automatic logic signed [sci_pkg::CW-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[sci_pkg::CW-1:0];
	endfunction

	// random segment: mostly near the circle, some noise, tangent and degenerate cases
	function automatic sci_pkg::sci_in_t rand_segment();
		sci_pkg::sci_in_t s;
		logic [7*32-1:0] rnd;
		longint cx, cy, r, span;
		int sh, mode;
		mode = $urandom_range(0, 9);
		sh = $urandom_range(3, 29);
		cx = longint'($signed($urandom)) >>> (31 - sh);
		cy = longint'($signed($urandom)) >>> (31 - sh);
		r = longint'($urandom_range(0, 1 << sh));
		span = 2 * r + 2;
		s.center_x = clamp_coord(cx);
		s.center_y = clamp_coord(cy);
		s.circle_radius = r[sci_pkg::RW-1:0];
		case (mode)
			0: begin
				rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				s = rnd[$bits(sci_pkg::sci_in_t)-1:0];
			end
			1: begin
				s.seg_x1 = clamp_coord(cx + longint'($signed($urandom)) % span);
				s.seg_y1 = clamp_coord(cy + longint'($signed($urandom)) % span);
				s.seg_x2 = s.seg_x1;
				s.seg_y2 = s.seg_y1;
			end
			2: begin
				// horizontal line touching the top of the circle
				s.seg_y1 = clamp_coord(cy + r);
				s.seg_y2 = s.seg_y1;
				s.seg_x1 = clamp_coord(cx - longint'($urandom_range(0, 1 << sh)) - 1);
				s.seg_x2 = clamp_coord(cx + longint'($signed($urandom)) % span);
			end
			default: begin
				s.seg_x1 = clamp_coord(cx + longint'($signed($urandom)) % span);
				s.seg_y1 = clamp_coord(cy + longint'($signed($urandom)) % span);
				s.seg_x2 = clamp_coord(cx + longint'($signed($urandom)) % span);
				s.seg_y2 = clamp_coord(cy + longint'($signed($urandom)) % span);
			end
		endcase
		return s;
	endfunction

	// driver: bursts of transfers with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		logic nv;
		sci_pkg::sci_in_t nd;
		nv = in_valid;
		nd = in_data;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_points(in_data);
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (!send_hold && pending_segs.size() > 0) begin
					nd = pending_segs.pop_front();
					nv = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else
						burst_left--;
				end
			end
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// receiver: stall pattern, plus one long hold on request
	int hold_seen = 0;
	int hold_left = 0;
	int mode_left = 0;
	int stall_pct = 0;
	always @(posedge clk) begin
		logic rdy;
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			mode_left = $urandom_range(10, 80);
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else
			rdy = ($urandom_range(0, 99) >= stall_pct);
		out_ready <= arst_n && rdy;
	end

	// monitor and watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		sci_pkg::sci_out_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected result %p", $realtime, out_data);
					errors++;
				end else begin
					e = expected_points.pop_front();
					if (out_data.hit !== e.hit || out_data.root_kind !== e.root_kind ||
					    out_data.point_x !== e.point_x || out_data.point_y !== e.point_y ||
					    out_data.last !== e.last) begin
						$display("%0t: mismatch expected %p actual %p", $realtime, e, out_data);
						errors++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, %0d results outstanding", $realtime,
				         expected_points.size());
				$display("** segment_circle_intersection: FAILED **");
				$finish;
			end
		end
	end

	task automatic write_threshold(input logic [sci_pkg::TW-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_thr = v;
	endtask

	task automatic wait_drained();
		while (pending_segs.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic add_segment(input longint x1, y1, x2, y2, cx, cy, input longint r);
		sci_pkg::sci_in_t s;
		s.seg_x1 = clamp_coord(x1);
		s.seg_y1 = clamp_coord(y1);
		s.seg_x2 = clamp_coord(x2);
		s.seg_y2 = clamp_coord(y2);
		s.center_x = clamp_coord(cx);
		s.center_y = clamp_coord(cy);
		s.circle_radius = r[sci_pkg::RW-1:0];
		pending_segs.push_back(s);
	endtask

	// stimulus phases
	initial begin
		logic [sci_pkg::TW-1:0] thr_set[5];
		thr_set = '{sci_pkg::THR_RESET, '0, '1, 32'd0, sci_pkg::THR_RESET};
		thr_set[3] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: crossings, tangent, miss, degenerate, extremes
		add_segment(-3 <<< 16, 0, 3 <<< 16, 0, 0, 0, 1 <<< 16);
		add_segment(0, 0, 3 <<< 16, 0, 0, 0, 1 <<< 16);
		add_segment(-5 <<< 16, 1 <<< 16, 5 <<< 16, 1 <<< 16, 0, 0, 1 <<< 16);
		add_segment(2 <<< 16, 1 <<< 16, 5 <<< 16, 1 <<< 16, 0, 0, 1 <<< 16);
		add_segment(-5 <<< 16, 2 <<< 16, 5 <<< 16, 2 <<< 16, 0, 0, 1 <<< 16);
		add_segment(7 <<< 16, 7 <<< 16, 7 <<< 16, 7 <<< 16, 7 <<< 16, 7 <<< 16, 0);
		add_segment(0, 0, 0, 0, 0, 0, 5);
		add_segment(0, 0, 1 <<< 16, 0, 0, 0, 0);
		add_segment(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
		            0, 0, 64'sd2147483647);
		add_segment(64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
		            64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
		add_segment(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
		            64'sd2147483647, 0, 64'sd2147483647);
		add_segment(64'sd2147483647, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
		            -64'sd2147483648, 64'sd2147483647, 0);
		add_segment(1, 1, -1, -1, 0, 0, 1);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) write_threshold(thr_set[ph]);
			if (ph == 2) begin
				// receiver holds off long while items keep coming
				hold_seq++;
			end
			for (int i = 0; i < 88; i++) pending_segs.push_back(rand_segment());
			if (ph == 1) begin
				// sender pauses mid-phase until all results are back
				while (pending_segs.size() > 40) @(posedge clk);
				send_hold = 1'b1;
				while (in_valid || expected_points.size() > 0) @(posedge clk);
				send_hold = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("** segment_circle_intersection: PASSED **");
		else
			$display("** segment_circle_intersection: FAILED **");
		$finish;
	end

endmodule

[files.f]
design/sci_pkg.sv
design/segment_circle_intersection.sv
design/sci_checker.sv
test/testbench.sv
